FILE: hw/rtl/iorkb_pkg.sv
// Shared types, register offsets and key code tables for the I/O register block.
package iorkb_pkg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the incoming access beat
        logic commit;    // execute the latched access and load the result register
    } iorkb_cmd_t;

    // Access kinds.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Register offsets with special read behavior.
    localparam logic [4:0] ADDR_KEY_CODE   = 5'h01;
    localparam logic [4:0] ADDR_CONST_A    = 5'h03;
    localparam logic [4:0] ADDR_TOGGLE     = 5'h07;
    localparam logic [4:0] ADDR_MASKED     = 5'h0a;
    localparam logic [4:0] ADDR_CONST_ZERO = 5'h0e;
    localparam logic [4:0] ADDR_SELF_CLEAR = 5'h10;
    localparam logic [4:0] ADDR_CONST_B    = 5'h16;
    localparam logic [4:0] ADDR_SET_AFTER  = 5'h1c;

    // Read values of the fixed and toggle registers.
    localparam logic [7:0] CONST_A_VALUE    = 8'd115;
    localparam logic [7:0] CONST_B_VALUE    = 8'd78;
    localparam logic [7:0] TOGGLE_SET_VALUE = 8'd224;
    localparam logic [7:0] TOGGLE_CLR_VALUE = 8'd96;

    // Key matrix geometry.
    localparam int NUM_REGS = 32;
    localparam int KEY_ROWS = 9;
    localparam int KEY_COLS = 8;
    localparam int NUM_KEYS = KEY_ROWS * KEY_COLS;

    // Key codes in row-major order, without modifiers.
    localparam logic [7:0] KEY_PLAIN [0:NUM_KEYS-1] = '{
        8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h08, 8'h7f, 8'h2d,
        8'h37, 8'h38, 8'h39, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h40, 8'h5b,
        8'h1b, 8'h2b, 8'h34, 8'h35, 8'h36, 8'h61, 8'h73, 8'h64,
        8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b, 8'h3a,
        8'h0d, 8'h0a, 8'h1e, 8'h31, 8'h32, 8'h33, 8'h7a, 8'h78,
        8'h63, 8'h76, 8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f,
        8'h1d, 8'h1f, 8'h1c, 8'h30, 8'h2e, 8'h20, 8'h00, 8'h00
    };

    // Key codes in row-major order, with a modifier held.
    localparam logic [7:0] KEY_SHIFT [0:NUM_KEYS-1] = '{
        8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26,
        8'h2a, 8'h28, 8'h29, 8'h3d, 8'h10, 8'h08, 8'h7f, 8'h2d,
        8'h37, 8'h38, 8'h39, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50, 8'h40, 8'h7b,
        8'h1b, 8'h2b, 8'h34, 8'h35, 8'h36, 8'h41, 8'h53, 8'h44,
        8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b, 8'h2a,
        8'h0d, 8'h0a, 8'h1e, 8'h31, 8'h32, 8'h33, 8'h5a, 8'h58,
        8'h43, 8'h56, 8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f,
        8'h1d, 8'h1f, 8'h1c, 8'h30, 8'h2e, 8'h20, 8'h00, 8'h00
    };

endpackage

FILE: hw/rtl/iorkb_ctrl.sv
// Controller state machine: sequences capture and execution of each access beat.
module iorkb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output iorkb_pkg::iorkb_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    // Input is taken only while no access is pending execution.
    assign in_stall = (state_reg == ST_EXEC);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd.capture = in_valid && !in_stall;
        cmd.commit  = (state_reg == ST_EXEC) && out_free;
    end

    // Next state and result-valid flag.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/iorkb_dp.sv
// Datapath: captured access, register file, key matrix encoder and result register.
module iorkb_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  iorkb_pkg::iorkb_cmd_t cmd,
    input  logic                  req_type,
    input  logic [4:0]            reg_addr,
    input  logic [7:0]            write_data,
    input  logic [63:0]           key_rows_low,
    input  logic [7:0]            key_row_last,
    input  logic [2:0]            modifier_keys,
    output logic [7:0]            read_data
);

    // Captured access.
    logic        req_type_reg;
    logic [4:0]  addr_reg;
    logic [7:0]  wdata_reg;
    logic [iorkb_pkg::NUM_KEYS-1:0] keys_reg;
    logic        shift_reg;

    // Register file and result register.
    logic [7:0] rf_reg [0:iorkb_pkg::NUM_REGS-1];
    logic [7:0] read_data_reg;

    // Key encoder signals.
    logic [iorkb_pkg::KEY_ROWS-1:0] row_any;
    logic [2:0] row_col [0:iorkb_pkg::KEY_ROWS-1];
    logic [3:0] win_row;
    logic [2:0] win_col;
    logic       key_down;
    logic [6:0] key_idx;
    logic [7:0] key_code;

    // Execution signals.
    logic [7:0] rd_cur;
    logic [7:0] result;
    logic       rf_we;
    logic [7:0] rf_wd;

    // Capture the access beat.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            addr_reg     <= reg_addr;
            wdata_reg    <= write_data;
            keys_reg     <= {key_row_last, key_rows_low};
            shift_reg    <= |modifier_keys;
        end
    end

    // Per-row encoder: highest column whose key is down (active low).
    always_comb
    begin
        for (int r = 0; r < iorkb_pkg::KEY_ROWS; r++)
        begin
            row_any[r] = 1'b0;
            row_col[r] = 3'd0;
            for (int c = 0; c < iorkb_pkg::KEY_COLS; c++)
            begin
                if (!keys_reg[r * iorkb_pkg::KEY_COLS + c])
                begin
                    row_any[r] = 1'b1;
                    row_col[r] = 3'(c);
                end
            end
        end
    end

    // Row select: the highest row with a key down wins.
    always_comb
    begin
        win_row = 4'd0;
        win_col = 3'd0;
        for (int r = 0; r < iorkb_pkg::KEY_ROWS; r++)
        begin
            if (row_any[r])
            begin
                win_row = 4'(r);
                win_col = row_col[r];
            end
        end
        key_down = |row_any;
        key_idx  = {win_row, win_col};
        if (!key_down)
        begin
            key_code = 8'd0;
        end
        else if (shift_reg)
        begin
            key_code = iorkb_pkg::KEY_SHIFT[key_idx];
        end
        else
        begin
            key_code = iorkb_pkg::KEY_PLAIN[key_idx];
        end
    end

    // Access execution: read value and register file update.
    always_comb
    begin
        rd_cur = rf_reg[addr_reg];
        result = 8'd0;
        rf_we  = 1'b0;
        rf_wd  = wdata_reg;
        if (req_type_reg == iorkb_pkg::REQ_WRITE)
        begin
            rf_we = 1'b1;
        end
        else
        begin
            unique case (addr_reg)
                iorkb_pkg::ADDR_KEY_CODE:
                begin
                    result = key_code;
                end
                iorkb_pkg::ADDR_CONST_A:
                begin
                    result = iorkb_pkg::CONST_A_VALUE;
                end
                iorkb_pkg::ADDR_TOGGLE:
                begin
                    rf_we  = 1'b1;
                    rf_wd  = rd_cur ^ 8'h01;
                    result = rf_wd[0] ? iorkb_pkg::TOGGLE_SET_VALUE
                                      : iorkb_pkg::TOGGLE_CLR_VALUE;
                end
                iorkb_pkg::ADDR_MASKED:
                begin
                    result = rd_cur & 8'hfe;
                end
                iorkb_pkg::ADDR_CONST_ZERO:
                begin
                    result = 8'd0;
                end
                iorkb_pkg::ADDR_SELF_CLEAR:
                begin
                    if (rd_cur[6] && rd_cur[0])
                    begin
                        rf_we  = 1'b1;
                        rf_wd  = 8'd0;
                        result = 8'd0;
                    end
                    else
                    begin
                        result = rd_cur;
                    end
                end
                iorkb_pkg::ADDR_CONST_B:
                begin
                    result = iorkb_pkg::CONST_B_VALUE;
                end
                iorkb_pkg::ADDR_SET_AFTER:
                begin
                    rf_we  = 1'b1;
                    rf_wd  = rd_cur | 8'h01;
                    result = rd_cur;
                end
                default:
                begin
                    result = rd_cur;
                end
            endcase
        end
    end

    // Register file, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < iorkb_pkg::NUM_REGS; i++)
            begin
                rf_reg[i] <= 8'd0;
            end
        end
        else if (cmd.commit && rf_we)
        begin
            rf_reg[addr_reg] <= rf_wd;
        end
    end

    // Result register holds the beat until the consumer takes it.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            read_data_reg <= result;
        end
    end

    assign read_data = read_data_reg;

endmodule

FILE: hw/rtl/io_register_block_with_key_scan_top.sv
// Top level of the byte register block with key matrix scan.
// A bank of 32 byte registers serves one read or write beat at a time. Each beat is first
// captured and then executed against the register file and the key matrix encoder; no new
// beat is taken while a captured beat awaits execution. The result register lets one
// finished result wait for the consumer while the next beat is already taken; execution of
// that beat then waits until the result register frees. Address 1 returns the code of the
// highest-priority key held down in the 9x8 active-low matrix (later row, then later
// column, wins), from the shifted table when any modifier is held, and 0 when no key is
// down. Writes always return 0.
module io_register_block_with_key_scan_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [4:0]  reg_addr,
    input  logic [7:0]  write_data,
    input  logic [63:0] key_rows_low,
    input  logic [7:0]  key_row_last,
    input  logic [2:0]  modifier_keys,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data
);

    iorkb_pkg::iorkb_cmd_t cmd;

    // Access sequencing.
    iorkb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Register file and key encoder.
    iorkb_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .req_type      (req_type),
        .reg_addr      (reg_addr),
        .write_data    (write_data),
        .key_rows_low  (key_rows_low),
        .key_row_last  (key_row_last),
        .modifier_keys (modifier_keys),
        .read_data     (read_data)
    );

endmodule
